>>> hw/rtl/dlv_pkg.sv
package dlv_pkg;

  // Delay line geometry
  localparam int unsigned LineDepth = 128;
  localparam int unsigned AddrW     = $clog2(LineDepth);

  localparam int unsigned SampleW = 16;
  localparam int unsigned FracW   = 16;
  localparam int unsigned PhaseW  = 32;
  localparam int unsigned ShiftW  = 5;

  // Integer bits of the read position start at this bit
  localparam int unsigned PosFracBits = 24;
  localparam int unsigned FracLsb     = 8;

  localparam logic [PhaseW-1:0] LfoStep = 32'd579632;

  // Reset values of the configuration registers
  localparam logic [ShiftW-1:0] SwayShiftRst = 5'd2;
  localparam logic              DryMixRst    = 1'b0;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 5;
  localparam logic [CfgIdxW-1:0] CfgSwayShift = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDryMixOn  = 2'd1;

  // One request queued between the front and the back end
  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic [AddrW-1:0]          wr_idx;
    logic [AddrW-1:0]          rd_idx;
    logic [FracW-1:0]          frac;
  } req_t;

endpackage

>>> hw/rtl/delay_line_vibrato_unit.sv
// Triangle-LFO delay-line vibrato.
// Input channel (in_valid_i / in_ready_o / sample_in_i): one signed 16-bit
//   sample per request. Each sample is stored in a 128-entry delay line and one
//   signed 16-bit result comes back on the output channel, in order.
// Output channel (out_valid_o / out_ready_i / sample_out_o): result held in an
//   output register until taken.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i):
//   index 0 = vibrato depth shift (5 bits), index 1 = dry mix enable (bit 0).
//   Always ready; write only while no request is in flight.
// Path: request queue, stage 1 (delay line), stage 2 (product), output register.
// Throughput: one request per cycle while the receiver takes results, set by the
//   two-read/one-write delay line stage and a single interpolation multiplier stage.
// Reset: delay line reads as all zeros (per-entry valid bits), write pointer
//   and LFO phase clear, depth shift = 2, dry mix off. No clearing pass.
// Stall: when the receiver holds off, the back pipeline freezes and the
//   front keeps taking requests until the request queue fills.
module delay_line_vibrato_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [15:0]             sample_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [15:0]             sample_out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dlv_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [dlv_pkg::CfgDataW-1:0]   cfg_data_i
);

  logic [dlv_pkg::ShiftW-1:0] sway_shift_q;
  logic                       dry_mix_on_q;

  logic          push, q_full, q_valid, pop;
  dlv_pkg::req_t push_req, pop_req;

  // Configuration registers: writes always land
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sway_shift_q <= dlv_pkg::SwayShiftRst;
      dry_mix_on_q <= dlv_pkg::DryMixRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dlv_pkg::CfgSwayShift: sway_shift_q <= cfg_data_i[dlv_pkg::ShiftW-1:0];
        dlv_pkg::CfgDryMixOn:  dry_mix_on_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Front: take the sample, form the read position, advance LFO and pointer
  dlv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .sway_shift_i (sway_shift_q),
    .push_o       (push),
    .req_o        (push_req),
    .q_full_i     (q_full)
  );

  // Queue: decouple the front from back-pressure on the output
  dlv_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (push_req),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .req_o   (pop_req)
  );

  // Back: write and read the delay line, interpolate, mix, hold the result
  dlv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .req_i        (pop_req),
    .pop_o        (pop),
    .dry_mix_on_i (dry_mix_on_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o)
  );

endmodule

>>> hw/rtl/dlv_front.sv
module dlv_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [15:0]            sample_in_i,
  input  logic [dlv_pkg::ShiftW-1:0]    sway_shift_i,
  output logic                          push_o,
  output dlv_pkg::req_t                 req_o,
  input  logic                          q_full_i
);

  logic [dlv_pkg::AddrW-1:0]  wr_pos_q, wr_pos_d;
  logic [dlv_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [dlv_pkg::PhaseW-1:0] tri_wave;
  logic [dlv_pkg::PhaseW-1:0] sway;
  logic [dlv_pkg::PhaseW-1:0] rd_pos;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Fold the phase into a triangle: rise to half scale, then fall back
  assign tri_wave = phase_q[dlv_pkg::PhaseW-1] ? (dlv_pkg::PhaseW'(0) - phase_q) : phase_q;
  assign sway     = tri_wave >> sway_shift_i;
  assign rd_pos   = {wr_pos_q, dlv_pkg::PosFracBits'(0)} - sway;

  always_comb begin
    req_o.sample = sample_in_i;
    req_o.wr_idx = wr_pos_q;
    req_o.rd_idx = rd_pos[dlv_pkg::PosFracBits +: dlv_pkg::AddrW];
    req_o.frac   = rd_pos[dlv_pkg::FracLsb +: dlv_pkg::FracW];
  end

  always_comb begin
    wr_pos_d = wr_pos_q;
    phase_d  = phase_q;
    if (push_o) begin
      wr_pos_d = wr_pos_q + dlv_pkg::AddrW'(1);
      phase_d  = phase_q + dlv_pkg::LfoStep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pos_q <= '0;
      phase_q  <= '0;
    end else begin
      wr_pos_q <= wr_pos_d;
      phase_q  <= phase_d;
    end
  end

endmodule

>>> hw/rtl/dlv_queue.sv
module dlv_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dlv_pkg::req_t req_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output dlv_pkg::req_t req_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dlv_pkg::req_t       slots_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign req_o   = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= req_i;
    end
  end

endmodule

>>> hw/rtl/dlv_back.sv
module dlv_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  dlv_pkg::req_t        req_i,
  output logic                 pop_o,
  input  logic                 dry_mix_on_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [15:0]   sample_out_o
);

  localparam int unsigned SW   = dlv_pkg::SampleW;
  localparam int unsigned DW   = SW + 1;
  localparam int unsigned ProdW = dlv_pkg::FracW + 1 + DW;

  logic signed [SW-1:0] line_mem [dlv_pkg::LineDepth];
  logic [dlv_pkg::LineDepth-1:0] vld_q;

  logic en;
  logic [dlv_pkg::AddrW-1:0] idx_b;

  // Stage 1: write and read the delay line
  logic                 s1_valid_q;
  logic signed [SW-1:0] s1_x_q, s1_rd_a_q, s1_rd_b_q;
  logic [dlv_pkg::FracW-1:0] s1_frac_q;
  logic                 s1_fwd_a_q, s1_fwd_b_q, s1_vld_a_q, s1_vld_b_q;

  // Stage 2: interpolation product
  logic                 s2_valid_q;
  logic signed [SW-1:0] s2_x_q, s2_a_q;
  logic signed [ProdW-1:0] s2_prod_q;

  logic                 out_valid_q;
  logic signed [SW-1:0] out_q;

  logic signed [SW-1:0] a_val, b_val;
  logic signed [DW-1:0] diff;
  logic signed [ProdW-1:0] prod_d, a_ext, acc;
  logic signed [SW-1:0] wet, half, out_d;

  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && q_valid_i;
  assign idx_b = req_i.rd_idx + dlv_pkg::AddrW'(1);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      line_mem[req_i.wr_idx] <= req_i.sample;
      s1_rd_a_q <= line_mem[req_i.rd_idx];
      s1_rd_b_q <= line_mem[idx_b];
      s1_x_q    <= req_i.sample;
      s1_frac_q <= req_i.frac;
      s1_fwd_a_q <= (req_i.rd_idx == req_i.wr_idx);
      s1_fwd_b_q <= (idx_b == req_i.wr_idx);
      s1_vld_a_q <= vld_q[req_i.rd_idx];
      s1_vld_b_q <= vld_q[idx_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pop_o) begin
      vld_q[req_i.wr_idx] <= 1'b1;
    end
  end

  // The slot written this request is seen by its own reads; unwritten slots read zero
  assign a_val = s1_fwd_a_q ? s1_x_q : (s1_vld_a_q ? s1_rd_a_q : '0);
  assign b_val = s1_fwd_b_q ? s1_x_q : (s1_vld_b_q ? s1_rd_b_q : '0);
  assign diff  = DW'(b_val) - DW'(a_val);
  assign prod_d = ProdW'($signed({1'b0, s1_frac_q}) * diff);

  // (0xFFFF - s) * a + s * b == a * 65536 - a + s * (b - a)
  assign a_ext = ProdW'(s2_a_q);
  assign acc   = (a_ext <<< dlv_pkg::FracW) - a_ext + s2_prod_q;
  assign wet   = acc[dlv_pkg::FracW +: SW];
  assign half  = s2_x_q >>> 1;
  assign out_d = wet + (dry_mix_on_i ? half : SW'(0));

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_x_q    <= s1_x_q;
      s2_a_q    <= a_val;
      s2_prod_q <= prod_d;
      out_q     <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= q_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

endmodule

>>> dv/delay_line_vibrato_unit_tb.sv
module delay_line_vibrato_unit_tb;

  // Index with no register behind it; a write there must change nothing
  localparam logic [dlv_pkg::CfgIdxW-1:0] CfgUnusedIdx = 2'd3;

  // Receiver hold-off used to back the block up into its input
  localparam int HoldCycles   = 300;
  localparam int PhaseCount   = 8;
  localparam int PhaseSamples = 140;

  // Expected-output tracker: keeps its own copy of the delay line, write
  // pointer, LFO phase and both settings, and predicts every output.
  class vibrato_tracker;
    logic signed [dlv_pkg::SampleW-1:0] delay_line [dlv_pkg::LineDepth];
    logic [dlv_pkg::AddrW-1:0]          wr_pos;
    logic [dlv_pkg::PhaseW-1:0]         phase;
    logic [dlv_pkg::ShiftW-1:0]         sway;
    logic                               mix_on;
    logic signed [dlv_pkg::SampleW-1:0] pending_outputs [$];
    int                                 mismatches;
    int                                 samples_seen;
    int                                 outputs_seen;

    function new();
      foreach (delay_line[i]) delay_line[i] = '0;
      wr_pos       = '0;
      phase        = '0;
      sway         = dlv_pkg::SwayShiftRst;
      mix_on       = dlv_pkg::DryMixRst;
      mismatches   = 0;
      samples_seen = 0;
      outputs_seen = 0;
    endfunction

    function void set_reg(logic [dlv_pkg::CfgIdxW-1:0] idx,
                          logic [dlv_pkg::CfgDataW-1:0] data);
      case (idx)
        dlv_pkg::CfgSwayShift: sway = data;
        dlv_pkg::CfgDryMixOn:  mix_on = data[0];
        default: ;
      endcase
    endfunction

    // Store the sample, read two neighbors behind the write point, blend them
    function void take_sample(logic signed [dlv_pkg::SampleW-1:0] x);
      logic [dlv_pkg::PhaseW-1:0]         tri_val;
      logic [dlv_pkg::PhaseW-1:0]         rd_pos;
      logic [dlv_pkg::AddrW-1:0]          ia;
      logic [dlv_pkg::AddrW-1:0]          ib;
      logic [dlv_pkg::FracW-1:0]          frac;
      longint                             acc;
      logic signed [dlv_pkg::SampleW-1:0] y;
      delay_line[wr_pos] = x;
      tri_val = phase[dlv_pkg::PhaseW-1] ? (32'h8000_0000 + (32'h8000_0000 - phase))
                                         : phase;
      rd_pos  = {1'b0, wr_pos, 24'h0} - (tri_val >> sway);
      ia      = rd_pos[30:dlv_pkg::PosFracBits];
      ib      = ia + 1'b1;
      frac    = rd_pos[dlv_pkg::PosFracBits-1:dlv_pkg::FracLsb];
      acc     = longint'(32'h0000_FFFF - {16'h0, frac}) * longint'(delay_line[ia])
              + longint'({16'h0, frac}) * longint'(delay_line[ib]);
      y       = dlv_pkg::SampleW'(acc >>> dlv_pkg::FracW);
      if (mix_on) y = y + (x >>> 1);
      pending_outputs.push_back(y);
      phase = phase + dlv_pkg::LfoStep;
      wr_pos = wr_pos + 1'b1;
      samples_seen++;
    endfunction

    function void compare_output(logic signed [dlv_pkg::SampleW-1:0] got);
      logic signed [dlv_pkg::SampleW-1:0] want;
      outputs_seen++;
      if (pending_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: output %0d (0x%04h) arrived with nothing outstanding",
                   got, got);
        return;
      end
      want = pending_outputs.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: output #%0d expected %0d (0x%04h) got %0d (0x%04h)",
                   outputs_seen, want, want, got, got);
      end
    endfunction

    function int pending();
      return pending_outputs.size();
    endfunction
  endclass

  logic                               clk_i;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic signed [dlv_pkg::SampleW-1:0] sample_in_i;
  logic                               out_valid_o;
  logic                               out_ready_i;
  logic signed [dlv_pkg::SampleW-1:0] sample_out_o;
  logic                               cfg_valid_i;
  logic                               cfg_ready_o;
  logic [dlv_pkg::CfgIdxW-1:0]        cfg_index_i;
  logic [dlv_pkg::CfgDataW-1:0]       cfg_data_i;

  vibrato_tracker tracker = new();

  // Set by the stimulus to ask the sink for one long hold-off
  logic        hold_req = 1'b0;
  int          reg_writes = 0;
  logic [31:0] shifts_used = '0;

  delay_line_vibrato_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watch all three channels at the rising edge; values seen here are the
  // ones the block sampled. Apply settings first so a request in the same
  // cycle would see them (never happens: writes go in only while idle).
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        tracker.set_reg(cfg_index_i, cfg_data_i);
        reg_writes++;
        if (cfg_index_i == dlv_pkg::CfgSwayShift) shifts_used[cfg_data_i] = 1'b1;
      end
      if (in_valid_i && in_ready_o) tracker.take_sample(sample_in_i);
      if (out_valid_o && out_ready_i) tracker.compare_output(sample_out_o);
    end
  end

  // Result sink: alternate ready stretches and gaps, mostly short gaps, a few
  // long ones, now and then a long stretch with no gap. On request, hold off
  // for HoldCycles so the block fills and stalls its input.
  initial begin : result_sink
    int run_left;
    int gap_left;
    int hold_left;
    run_left    = 0;
    gap_left    = 0;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (run_left == 0 && gap_left == 0) begin
        run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 30);
        gap_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                              : $urandom_range(10, 40);
      end
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else if (run_left > 0) begin
        out_ready_i = 1'b1;
        run_left--;
      end else begin
        out_ready_i = 1'b0;
        gap_left--;
      end
    end
  end

  // Offer one request and hold it until the block takes it. Call at a
  // falling edge; return at a falling edge with valid dropped.
  task automatic send_sample(input logic signed [dlv_pkg::SampleW-1:0] x);
    in_valid_i  = 1'b1;
    sample_in_i = x;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Hold the sender until every outstanding output has come back
  task automatic wait_drained();
    while (tracker.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [dlv_pkg::CfgIdxW-1:0]  idx,
                           input logic [dlv_pkg::CfgDataW-1:0] data);
    wait_drained();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic sender_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return;
    else if (pick < 90) repeat ($urandom_range(1, 3)) @(negedge clk_i);
    else repeat ($urandom_range(6, 30)) @(negedge clk_i);
  endtask

  function automatic logic signed [dlv_pkg::SampleW-1:0] pick_sample();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 4))
        0:       return 16'sh7FFF;
        1:       return 16'sh8000;
        2:       return 16'shFFFF;
        3:       return 16'sh0001;
        default: return 16'sh0000;
      endcase
    end else if (sel == 1) begin
      return dlv_pkg::SampleW'($urandom_range(0, 512)) - 16'sd256;
    end
    return dlv_pkg::SampleW'($urandom());
  endfunction

  initial begin : stimulus
    logic [dlv_pkg::ShiftW-1:0] sway;
    logic                       mix;
    in_valid_i  = 1'b0;
    sample_in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = dlv_pkg::CfgSwayShift;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings (shift 2, dry mix off): full-scale and alternating
    // patterns against the zeroed delay line
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'shFFFF);
    send_sample(16'sh0000);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);

    // Unshifted triangle with dry mix on: full-scale inputs push the sum
    // past 16 bits and must wrap
    write_reg(dlv_pkg::CfgSwayShift, 5'd0);
    write_reg(dlv_pkg::CfgDryMixOn, 5'd1);
    send_sample(16'sh7FFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    send_sample(16'shFFFF);
    send_sample(16'sh0001);

    // Deepest shift: LFO vanishes, so the read lands on the slot just written
    write_reg(dlv_pkg::CfgSwayShift, 5'd31);
    write_reg(dlv_pkg::CfgDryMixOn, 5'd0);
    send_sample(16'sh1234);
    send_sample(16'shEDCC);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);

    // Shift of one, next to the shallowest, fractions mixing opposite-signed neighbors
    write_reg(dlv_pkg::CfgSwayShift, 5'd1);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh8001);

    // Random phases, each with its own depth and mix setting; the first
    // three pin shifts 31, 0 and 1
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0:       sway = 5'd31;
        1:       sway = 5'd0;
        2:       sway = 5'd1;
        default: sway = dlv_pkg::ShiftW'($urandom_range(0, 31));
      endcase
      mix = (p < 4) ? p[0] : 1'($urandom_range(0, 1));
      if (p == 3) write_reg(CfgUnusedIdx, dlv_pkg::CfgDataW'($urandom()));
      write_reg(dlv_pkg::CfgSwayShift, sway);
      // Upper data bits are don't-care for the mix enable; toggle them anyway
      write_reg(dlv_pkg::CfgDryMixOn, {4'($urandom_range(0, 15)), mix});
      if (p == 4) hold_req = 1'b1;
      for (int i = 0; i < PhaseSamples; i++) begin
        // Keep pushing back-to-back while the sink holds off, so the
        // request queue fills and the input stalls
        if (!(p == 4 && i < 40)) sender_gap();
        if (p == 5 && i == 70) wait_drained();
        send_sample(pick_sample());
      end
    end

    wait_drained();
    repeat (12) @(negedge clk_i);

    $display("Run covered %0d samples, %0d outputs, %0d register writes,",
             tracker.samples_seen, tracker.outputs_seen, reg_writes);
    $display("%0d distinct depth shifts (0, 1 and 31 included), dry mix on and off.",
             $countones(shifts_used));
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d bad outputs, %0d still outstanding",
               tracker.mismatches, tracker.pending());
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin : watchdog
    #8000000;
    $display("Timeout: %0d outputs still outstanding", tracker.pending());
    $display("Mismatches found");
    $finish;
  end

endmodule
